/* design/hbd_pkg.sv */
// Shared types, constants and calendar helpers for the hours-between-dates block.
package hbd_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned HoursW  = 15;
  localparam int unsigned StatusW = 2;

  // floor(y / 100) == (y * DivRecip) >> DivShift for every 14-bit year
  localparam int unsigned QuotW    = 8;
  localparam int unsigned RecipW   = 13;
  localparam int unsigned ProdW    = YearW + RecipW;
  localparam int unsigned DivShift = 19;
  localparam logic [RecipW-1:0] DivRecip = 13'd5243;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthApr = 4'd4;
  localparam logic [MonthW-1:0] MonthJun = 4'd6;
  localparam logic [MonthW-1:0] MonthSep = 4'd9;
  localparam logic [MonthW-1:0] MonthNov = 4'd11;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_SPAN   = 2'd1,
    STATUS_BEFORE = 2'd2,
    STATUS_MONTH  = 2'd3
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic quot;
    logic setup;
    logic step;
    logic finish;
  } hbd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_done;
    logic out_free;
  } hbd_sts_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (m)
      MonthFeb: len = leap ? 5'd29 : 5'd28;
      MonthApr, MonthJun, MonthSep, MonthNov: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* design/hbd_ctrl.sv */
// Sequencer for one date-pair transaction: capture, divide, setup, month walk, finish.
module hbd_ctrl
  import hbd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  hbd_sts_t sts_i,
  output hbd_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_QUOT   = 5'b00010,
    S_SETUP  = 5'b00100,
    S_WALK   = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_QUOT;
        end
      end
      S_QUOT: begin
        cmd_o.quot = 1'b1;
        state_d    = S_SETUP;
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = S_WALK;
      end
      S_WALK: begin
        if (sts_i.walk_done) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_FINISH: begin
        // hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

/* design/hbd_dp.sv */
// Datapath: input capture, leap-year divide, month walk accumulator, output register.
module hbd_dp
  import hbd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hbd_cmd_t            cmd_i,
  output hbd_sts_t            sts_o,
  input  logic [YearW-1:0]    start_year_i,
  input  logic [MonthW-1:0]   start_month_i,
  input  logic [DayW-1:0]     start_day_i,
  input  logic [HourW-1:0]    start_hour_i,
  input  logic [YearW-1:0]    end_year_i,
  input  logic [MonthW-1:0]   end_month_i,
  input  logic [DayW-1:0]     end_day_i,
  input  logic [HourW-1:0]    end_hour_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [HoursW-1:0]   hour_count_o,
  output logic [StatusW-1:0]  status_o
);

  localparam int unsigned AccW = 12;
  localparam int unsigned HrsW = 17;
  localparam int unsigned CmpW = YearW + 1;

  logic [YearW-1:0]  sy_q, ey_q;
  logic [MonthW-1:0] sm_q, em_q;
  logic [DayW-1:0]   sd_q, ed_q;
  logic [HourW-1:0]  sh_q, eh_q;
  logic [QuotW-1:0]  qs_q, qe_q;
  logic [MonthW-1:0] cm_q, tgt_q;
  logic              cl_q, leap_e_q, neg_q;
  logic signed [AccW-1:0] acc_q;
  status_e           st_q;
  logic              out_valid_q;
  logic [HoursW-1:0] hours_q;
  status_e           ost_q;

  // leap test from the registered quotients
  function automatic logic is_leap(input logic [YearW-1:0] y, input logic [QuotW-1:0] q);
    logic [CmpW-1:0] q100;
    q100 = (CmpW'(q) << 6) + (CmpW'(q) << 5) + (CmpW'(q) << 2);
    return (y[1:0] == 2'b00) && ((q100 != CmpW'(y)) || (q[1:0] == 2'b00));
  endfunction

  logic [ProdW-1:0] prod_s, prod_e;
  logic             leap_s, leap_e, bad_month, same_year;
  logic signed [AccW-1:0] day_diff, year_add;
  logic [DayW-1:0]  step_len;
  logic signed [HrsW-1:0] days_x, hrs;

  logic [MonthW-1:0]      init_cm, init_tgt;
  logic                   init_cl, init_neg;
  logic signed [AccW-1:0] init_acc;
  status_e                init_st;

  assign prod_s = ProdW'(sy_q) * ProdW'(DivRecip);
  assign prod_e = ProdW'(ey_q) * ProdW'(DivRecip);

  assign leap_s    = is_leap(sy_q, qs_q);
  assign leap_e    = is_leap(ey_q, qe_q);
  assign bad_month = (sm_q == '0) || (sm_q > MonthDec) || (em_q == '0) || (em_q > MonthDec);
  assign same_year = (sy_q == ey_q);
  assign day_diff  = $signed(AccW'(ed_q)) - $signed(AccW'(sd_q));
  // a full year from (sy, sm) to (sy+1, sm); Feb 29 counts in whichever year holds it
  assign year_add  = $signed(AccW'(365)) +
                     $signed(AccW'((sm_q <= MonthFeb) ? leap_s : leap_e));

  always_comb begin
    init_cm  = sm_q;
    init_tgt = em_q;
    init_cl  = leap_s;
    init_neg = 1'b0;
    init_acc = day_diff;
    init_st  = STATUS_OK;
    if (bad_month) begin
      init_st = STATUS_MONTH;
    end else if (ey_q < sy_q) begin
      init_st = STATUS_BEFORE;
    end else if (CmpW'(ey_q) > CmpW'(sy_q) + CmpW'(1)) begin
      init_st = STATUS_SPAN;
    end else if (same_year && (em_q < sm_q)) begin
      // walk back from the end month to the start month and subtract
      init_cm  = em_q;
      init_tgt = sm_q;
      init_neg = 1'b1;
    end else if (!same_year && (em_q >= sm_q)) begin
      init_acc = day_diff + year_add;
      init_cl  = leap_e;
    end
  end

  assign step_len = month_len(cm_q, cl_q);

  assign days_x = HrsW'(acc_q);
  assign hrs    = (days_x <<< 4) + (days_x <<< 3)
                + $signed(HrsW'(eh_q)) - $signed(HrsW'(sh_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sy_q <= start_year_i;
      sm_q <= start_month_i;
      sd_q <= start_day_i;
      sh_q <= start_hour_i;
      ey_q <= end_year_i;
      em_q <= end_month_i;
      ed_q <= end_day_i;
      eh_q <= end_hour_i;
    end
    if (cmd_i.quot) begin
      qs_q <= QuotW'(prod_s >> DivShift);
      qe_q <= QuotW'(prod_e >> DivShift);
    end
    if (cmd_i.setup) begin
      leap_e_q <= leap_e;
      cl_q     <= init_cl;
      neg_q    <= init_neg;
      cm_q     <= init_cm;
      tgt_q    <= init_tgt;
      acc_q    <= init_acc;
      st_q     <= init_st;
    end
    if (cmd_i.step) begin
      acc_q <= neg_q ? acc_q - $signed(AccW'(step_len)) : acc_q + $signed(AccW'(step_len));
      if (cm_q == MonthDec) begin
        cm_q <= MonthJan;
        cl_q <= leap_e_q;
      end else begin
        cm_q <= cm_q + MonthW'(1);
      end
    end
    if (cmd_i.finish) begin
      if (st_q != STATUS_OK) begin
        hours_q <= '0;
        ost_q   <= st_q;
      end else if (hrs < 0) begin
        hours_q <= '0;
        ost_q   <= STATUS_BEFORE;
      end else begin
        hours_q <= hrs[HoursW-1:0];
        ost_q   <= STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.walk_done = (st_q != STATUS_OK) || (cm_q == tgt_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign hour_count_o = hours_q;
  assign status_o     = ost_q;

  a_walk_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (cm_q >= MonthJan) && (cm_q <= MonthDec))
    else $error("month walk left the calendar range");

  a_walk_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (st_q == STATUS_OK))
    else $error("month walk running on a rejected transaction");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (ost_q != STATUS_OK) |-> (hours_q == '0))
    else $error("error result carries nonzero hours");

  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_q) |-> $past(out_ready_i))
    else $error("result dropped without a transaction");

endmodule

/* design/hours_between_dates.sv */
// Top level of the hours-between-dates block: controller plus datapath.
// Takes a start and an end date-hour and returns the whole hours between them on the
// Gregorian calendar, with one result per input transaction. The end must fall in the
// start year or the year after; otherwise, or when the end precedes the start, or when
// a month is outside 1..12, status reports the error and hour_count is zero. Days and
// hours are not range checked and enter the arithmetic as given. An item is captured,
// divided, set up, walked over n months (n from 0 to 11) and finished, and only then
// can the next item be accepted; the month walk adds one month length per cycle.
// The result sits in an output register, and the next item is accepted while it waits
// to be taken.
module hours_between_dates
  import hbd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [YearW-1:0]   start_year_i,
  input  logic [MonthW-1:0]  start_month_i,
  input  logic [DayW-1:0]    start_day_i,
  input  logic [HourW-1:0]   start_hour_i,
  input  logic [YearW-1:0]   end_year_i,
  input  logic [MonthW-1:0]  end_month_i,
  input  logic [DayW-1:0]    end_day_i,
  input  logic [HourW-1:0]   end_hour_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [HoursW-1:0]  hour_count_o,
  output logic [StatusW-1:0] status_o
);

  hbd_cmd_t cmd;
  hbd_sts_t sts;

  hbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hbd_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .start_year_i  (start_year_i),
    .start_month_i (start_month_i),
    .start_day_i   (start_day_i),
    .start_hour_i  (start_hour_i),
    .end_year_i    (end_year_i),
    .end_month_i   (end_month_i),
    .end_day_i     (end_day_i),
    .end_hour_i    (end_hour_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hour_count_o  (hour_count_o),
    .status_o      (status_o)
  );

endmodule
